// File: sv/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

   // Default matrix dimension
   localparam int DIM_DEFAULT = 4;

   // Q16.16 element width and fraction bits
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * DATA_W;

   // Request operations
   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_MUL    = 2'd2,
      OP_SCALE  = 2'd3
   } op_type;

   // Request payload
   typedef struct packed {
      op_type                    opcode;
      logic [1:0]                row;
      logic [1:0]                col;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [1:0]                out_row;
      logic [1:0]                out_col;
      logic signed [DATA_W-1:0]  out_value;
      logic                      last;
   } rsp_type;

   // Control that travels with each element along the cell chain
   typedef struct packed {
      logic valid;
      logic scale;
      logic last;
   } tok_type;

endpackage

`default_nettype wire

// File: sv/mm4_cell.sv
// ----------------------------------------------------------------------------
// mm4_cell
// One cell of the chain: holds column CELL_IDX of A and row CELL_IDX of B,
// forms its product term for the passing element and adds it to the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_cell #(
   parameter int DIM      = mm4_pkg::DIM_DEFAULT,
   parameter int CELL_IDX = 0
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   load_a_en,
   input  wire logic                                   load_b_en,
   input  wire logic [$clog2(DIM)-1:0]                 load_addr,
   input  wire logic signed [mm4_pkg::DATA_W-1:0]      load_data,
   input  wire logic signed [mm4_pkg::DATA_W-1:0]      scalar,
   input  wire mm4_pkg::tok_type                       tok_in,
   input  wire logic [$clog2(DIM)-1:0]                 i_in,
   input  wire logic [$clog2(DIM)-1:0]                 j_in,
   input  wire logic signed [mm4_pkg::PROD_W-mm4_pkg::FRAC_W+$clog2(DIM):0] sum_in,
   output mm4_pkg::tok_type                            tok_out,
   output logic [$clog2(DIM)-1:0]                      i_out,
   output logic [$clog2(DIM)-1:0]                      j_out,
   output logic signed [mm4_pkg::PROD_W-mm4_pkg::FRAC_W+$clog2(DIM):0] sum_out
);

   localparam int IDX_W = $clog2(DIM);
   localparam int ACC_W = mm4_pkg::PROD_W - mm4_pkg::FRAC_W + IDX_W + 1;

   logic signed [mm4_pkg::DATA_W-1:0] col_a_ff [DIM];
   logic signed [mm4_pkg::DATA_W-1:0] row_b_ff [DIM];

   mm4_pkg::tok_type                  tok1_ff;
   logic [IDX_W-1:0]                  i1_ff, j1_ff;
   logic signed [ACC_W-1:0]           sum1_ff;
   logic signed [mm4_pkg::PROD_W-1:0] prod_ff;
   logic signed [mm4_pkg::DATA_W-1:0] opnd_a_in, opnd_b_in;

   mm4_pkg::tok_type                  tok2_ff;
   logic [IDX_W-1:0]                  i2_ff, j2_ff;
   logic signed [ACC_W-1:0]           sum2_ff;

   // Hold the stored column of A and row of B
   always_ff @(posedge clock) begin
      if (load_a_en) begin
         col_a_ff[load_addr] <= load_data;
      end
      if (load_b_en) begin
         row_b_ff[load_addr] <= load_data;
      end
   end

   // Select operands: B element for multiply, scalar on the matching column for scale
   always_comb begin
      opnd_a_in = col_a_ff[i_in];
      if (!tok_in.scale) begin
         opnd_b_in = row_b_ff[j_in];
      end else if (j_in == IDX_W'(CELL_IDX)) begin
         opnd_b_in = scalar;
      end else begin
         opnd_b_in = '0;
      end
   end

   // Stage one multiplies, stage two floors and accumulates
   always_ff @(posedge clock) begin
      prod_ff <= opnd_a_in * opnd_b_in;
      i1_ff   <= i_in;
      j1_ff   <= j_in;
      sum1_ff <= sum_in;
      i2_ff   <= i1_ff;
      j2_ff   <= j1_ff;
      sum2_ff <= sum1_ff + ACC_W'($signed(prod_ff[mm4_pkg::PROD_W-1:mm4_pkg::FRAC_W]));
      if (reset) begin
         tok1_ff <= '0;
         tok2_ff <= '0;
      end else begin
         tok1_ff <= tok_in;
         tok2_ff <= tok1_ff;
      end
   end

   assign tok_out = tok2_ff;
   assign i_out   = i2_ff;
   assign j_out   = j2_ff;
   assign sum_out = sum2_ff;

endmodule

`default_nettype wire

// File: sv/matrix4_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix4_multiply_engine
// DIM x DIM Q16.16 matrix engine: loads A and B, emits A*B or A*scalar.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low.
//   Load requests (A or B) write one element and give no result;
//   loads with an index not below DIM are dropped. Loads may follow each other
//   every cycle while busy is low.
//   Multiply and scale requests raise busy and stream DIM*DIM elements in
//   row-major order, one per cycle, each shown for one cycle with rsp_valid;
//   last marks the final element. The receiver cannot stall the stream.
//   Elements flow through a chain of DIM cells, each with a multiply stage and
//   then a floor-and-add stage, plus one saturation register; busy drops after
//   the last element is shown, and only then can the next request be accepted.
//   Reset clears the control; matrix contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_multiply_engine #(
   parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire mm4_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output mm4_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(DIM);
   localparam int ACC_W = mm4_pkg::PROD_W - mm4_pkg::FRAC_W + IDX_W + 1;

   logic                              accept;
   logic                              busy_ff;
   logic                              issue_ff;
   logic                              scale_ff;
   logic signed [mm4_pkg::DATA_W-1:0] scalar_ff;
   logic [IDX_W-1:0]                  i_ff, j_ff;
   logic                              issue_last;
   logic                              load_ok;

   mm4_pkg::tok_type                  tok  [DIM+1];
   logic [IDX_W-1:0]                  ci   [DIM+1];
   logic [IDX_W-1:0]                  cj   [DIM+1];
   logic signed [ACC_W-1:0]           csum [DIM+1];

   logic                              rsp_valid_ff;
   mm4_pkg::rsp_type                  rsp_ff;
   logic signed [mm4_pkg::DATA_W-1:0] sat_value;
   logic                              ovf;

   assign accept     = start && !busy_ff;
   assign load_ok    = (32'(req_data.row) < DIM) && (32'(req_data.col) < DIM);
   assign issue_last = (i_ff == IDX_W'(DIM - 1)) && (j_ff == IDX_W'(DIM - 1));

   // Sequence the element indices into the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         issue_ff <= 1'b0;
      end else begin
         if (accept && (req_data.opcode == mm4_pkg::OP_MUL ||
                        req_data.opcode == mm4_pkg::OP_SCALE)) begin
            busy_ff  <= 1'b1;
            issue_ff <= 1'b1;
         end else begin
            if (issue_ff && issue_last) begin
               issue_ff <= 1'b0;
            end
            if (rsp_valid_ff && rsp_ff.last) begin
               busy_ff <= 1'b0;
            end
         end
      end
      if (accept) begin
         scale_ff  <= (req_data.opcode == mm4_pkg::OP_SCALE);
         scalar_ff <= req_data.value;
         i_ff      <= '0;
         j_ff      <= '0;
      end else if (issue_ff) begin
         if (j_ff == IDX_W'(DIM - 1)) begin
            j_ff <= '0;
            i_ff <= i_ff + 1'b1;
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
   end

   // Feed the head of the chain
   assign tok[0]  = '{valid: issue_ff, scale: scale_ff, last: issue_last};
   assign ci[0]   = i_ff;
   assign cj[0]   = j_ff;
   assign csum[0] = '0;

   // Build the chain of cells
   for (genvar k = 0; k < DIM; k++) begin : g_cell
      mm4_cell #(
         .DIM      (DIM),
         .CELL_IDX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .load_a_en (accept && req_data.opcode == mm4_pkg::OP_LOAD_A && load_ok &&
                     req_data.col == 2'(k)),
         .load_b_en (accept && req_data.opcode == mm4_pkg::OP_LOAD_B && load_ok &&
                     req_data.row == 2'(k)),
         .load_addr (req_data.opcode == mm4_pkg::OP_LOAD_A ? IDX_W'(req_data.row)
                                                           : IDX_W'(req_data.col)),
         .load_data (req_data.value),
         .scalar    (scalar_ff),
         .tok_in    (tok[k]),
         .i_in      (ci[k]),
         .j_in      (cj[k]),
         .sum_in    (csum[k]),
         .tok_out   (tok[k+1]),
         .i_out     (ci[k+1]),
         .j_out     (cj[k+1]),
         .sum_out   (csum[k+1])
      );
   end

   // Saturate the final sum to 32 bits
   always_comb begin
      ovf = (csum[DIM][ACC_W-1:mm4_pkg::DATA_W-1] != '0) &&
            (csum[DIM][ACC_W-1:mm4_pkg::DATA_W-1] != '1);
      if (!ovf) begin
         sat_value = csum[DIM][mm4_pkg::DATA_W-1:0];
      end else if (csum[DIM][ACC_W-1]) begin
         sat_value = {1'b1, {(mm4_pkg::DATA_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(mm4_pkg::DATA_W-1){1'b1}}};
      end
   end

   // Register the result
   always_ff @(posedge clock) begin
      rsp_ff.out_row   <= 2'(ci[DIM]);
      rsp_ff.out_col   <= 2'(cj[DIM]);
      rsp_ff.out_value <= sat_value;
      rsp_ff.last      <= tok[DIM].last;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tok[DIM].valid;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Results only appear while a multiply or scale is in progress
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff) else $error("result outside busy window");

   // Busy drops right after the final element
   a_busy_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |=> !busy_ff) else $error("busy held after last");

   // Issuing implies busy
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> busy_ff) else $error("issuing while idle");

endmodule

`default_nettype wire

// File: bench/matrix4_multiply_engine_test.sv
// ----------------------------------------------------------------------------
// matrix4_multiply_engine_test
// Drives load, multiply and scale requests into the matrix engine and checks
// every streamed element against a Q16.16 model of the math: floored products,
// exact sums, and saturation to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix4_multiply_engine_test;

   localparam int N         = 4;
   localparam int MAX_CYCLE = 400000;

   logic             clock;
   logic             reset;
   logic             start;
   mm4_pkg::req_type req_data;
   logic             busy;
   logic             rsp_valid;
   mm4_pkg::rsp_type rsp_data;

   matrix4_multiply_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Model copy of both matrices and written flags
   logic signed [31:0] mat_a [16];
   logic signed [31:0] mat_b [16];
   bit                 a_set [16];
   bit                 b_set [16];
   mm4_pkg::rsp_type   expected_elems [$];
   int                 mismatches;
   int                 cycle_count;

   // Directed table; a row with has_exp set carries a fixed expected element
   typedef struct {
      mm4_pkg::req_type rq;
      bit               has_exp;
      mm4_pkg::rsp_type ex;
   } dir_row_type;
   dir_row_type dir_rows [$];

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Work out the result stream for one accepted request
   task automatic predict_matrix(input mm4_pkg::req_type r);
      logic signed [63:0] acc;
      logic signed [63:0] prod;
      mm4_pkg::rsp_type e;
      case (r.opcode)
         mm4_pkg::OP_LOAD_A: begin
            mat_a[r.row*N + r.col] = r.value;
            a_set[r.row*N + r.col] = 1'b1;
         end
         mm4_pkg::OP_LOAD_B: begin
            mat_b[r.row*N + r.col] = r.value;
            b_set[r.row*N + r.col] = 1'b1;
         end
         default: begin
            for (int i = 0; i < N; i++)
               for (int j = 0; j < N; j++) begin
                  if (r.opcode == mm4_pkg::OP_MUL) begin
                     acc = 0;
                     for (int k = 0; k < N; k++) begin
                        prod = 64'(mat_a[i*N+k]) * 64'(mat_b[k*N+j]);
                        acc  = acc + (prod >>> mm4_pkg::FRAC_W);
                     end
                  end else begin
                     prod = 64'(mat_a[i*N+j]) * 64'(r.value);
                     acc  = prod >>> mm4_pkg::FRAC_W;
                  end
                  if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                  if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                  e.out_row   = 2'(i);
                  e.out_col   = 2'(j);
                  e.out_value = acc[31:0];
                  e.last      = (i == N-1) && (j == N-1);
                  expected_elems.push_back(e);
               end
         end
      endcase
   endtask

   // Check each strobed element against the oldest expectation
   always @(posedge clock) begin
      mm4_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_elems.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected element %h", rsp_data);
         end else begin
            e = expected_elems.pop_front();
            if (rsp_data.out_row !== e.out_row || rsp_data.out_col !== e.out_col ||
                rsp_data.out_value !== e.out_value || rsp_data.last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp r%0d c%0d v%h l%0d, got r%0d c%0d v%h l%0d",
                           e.out_row, e.out_col, e.out_value, e.last,
                           rsp_data.out_row, rsp_data.out_col, rsp_data.out_value,
                           rsp_data.last);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
         $display("matrix4_multiply_engine_test: FAIL");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed(32'($urandom_range(0, 32'h3ffff)) - 32'h20000);
         3: return $signed(32'($urandom_range(0, 32'h7ffffff)) - 32'h4000000);
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic mm4_pkg::req_type rand_load(input bit to_b);
      mm4_pkg::req_type r;
      r.opcode = to_b ? mm4_pkg::OP_LOAD_B : mm4_pkg::OP_LOAD_A;
      r.row    = 2'($urandom);
      r.col    = 2'($urandom);
      r.value  = rand_value();
      return r;
   endfunction

   // Hand one request over at a falling edge, hold until taken
   int burst_left;
   task automatic send_req(input mm4_pkg::req_type r);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= r;
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_matrix(r);
      @(negedge clock);
   endtask

   function automatic dir_row_type mk_row(input mm4_pkg::op_type op, input int rw,
                                          input int cl, input logic signed [31:0] v);
      dir_row_type d;
      d.rq.opcode = op;
      d.rq.row    = 2'(rw);
      d.rq.col    = 2'(cl);
      d.rq.value  = v;
      d.has_exp   = 1'b0;
      d.ex        = '0;
      return d;
   endfunction

   initial begin
      dir_row_type      d;
      mm4_pkg::req_type r;
      bit               all_set;
      mismatches  = 0;
      cycle_count = 0;
      burst_left  = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      foreach (a_set[i]) begin
         a_set[i] = 1'b0; b_set[i] = 1'b0; mat_a[i] = 0; mat_b[i] = 0;
      end
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: load A as identity, B with extremes, then operate
      for (int i = 0; i < 16; i += 5)
         dir_rows.push_back(mk_row(mm4_pkg::OP_LOAD_A, i/4, i%4, 32'sh10000));
      for (int i = 0; i < 16; i++) begin
         if (i % 5 != 0) begin
            d = mk_row(mm4_pkg::OP_LOAD_A, i/4, i%4, 32'sh0);
            dir_rows.push_back(d);
         end
      end
      // B elements alternate max and min along each row; A is identity so A*B reproduces B
      for (int i = 0; i < 16; i++) begin
         d = mk_row(mm4_pkg::OP_LOAD_B, i/4, i%4, (i % 2) ? 32'sh80000000 : 32'sh7fffffff);
         dir_rows.push_back(d);
      end
      dir_rows.push_back(mk_row(mm4_pkg::OP_MUL, 3, 3, 32'sh0));
      // Scale of identity by max value: element (0,0) reads off as max
      d = mk_row(mm4_pkg::OP_SCALE, 2, 1, 32'sh7fffffff);
      d.has_exp = 1'b1;
      d.ex.out_row = 0; d.ex.out_col = 0; d.ex.out_value = 32'sh7fffffff; d.ex.last = 0;
      dir_rows.push_back(d);
      // Scale of identity by min value
      d = mk_row(mm4_pkg::OP_SCALE, 0, 0, 32'sh80000000);
      d.has_exp = 1'b1;
      d.ex.out_row = 0; d.ex.out_col = 0; d.ex.out_value = 32'sh80000000; d.ex.last = 0;
      dir_rows.push_back(d);
      // Saturating multiply: A full of max, B alternating max and min
      for (int i = 0; i < 16; i++)
         dir_rows.push_back(mk_row(mm4_pkg::OP_LOAD_A, i/4, i%4, 32'sh7fffffff));
      d = mk_row(mm4_pkg::OP_MUL, 1, 2, 32'sh12345678);
      dir_rows.push_back(d);
      d = mk_row(mm4_pkg::OP_SCALE, 3, 3, -32'sh8000);
      dir_rows.push_back(d);

      foreach (dir_rows[n]) begin
         send_req(dir_rows[n].rq);
         // Fixed expectation must agree with the first element predicted
         if (dir_rows[n].has_exp) begin
            if (expected_elems.size() < 16 ||
                expected_elems[expected_elems.size()-16] != dir_rows[n].ex) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("directed row %0d: first element differs from table", n);
            end
         end
      end

      // Random: mostly loads, operations once both matrices are fully written
      for (int n = 0; n < 417; n++) begin
         all_set = 1'b1;
         foreach (a_set[i]) if (!a_set[i] || !b_set[i]) all_set = 1'b0;
         if (all_set && $urandom_range(0, 9) < 2) begin
            r.opcode = $urandom_range(0, 1) ? mm4_pkg::OP_MUL : mm4_pkg::OP_SCALE;
            r.row    = 2'($urandom);
            r.col    = 2'($urandom);
            r.value  = rand_value();
         end else begin
            r = rand_load($urandom_range(0, 1));
         end
         send_req(r);
      end
      start <= 1'b0;

      while (expected_elems.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_elems.size() == 0) begin
         $display("matrix4_multiply_engine_test: PASS");
      end else begin
         $display("matrix4_multiply_engine_test: FAIL");
      end
      $finish;
   end

endmodule
